>>> rtl/core/wall_standard_utc_time_expand_top_assert.svh
// Assertion macros used by the checker file of the time expander.
// No dependencies; each macro builds one labeled concurrent assertion.
`ifndef WALL_STANDARD_UTC_TIME_EXPAND_TOP_ASSERT_SVH
`define WALL_STANDARD_UTC_TIME_EXPAND_TOP_ASSERT_SVH

// Same-cycle implication, checked out of reset.
`define WSUTE_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("wsute: same-cycle check failed");

// Next-cycle implication, checked out of reset.
`define WSUTE_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("wsute: next-cycle check failed");

`endif

>>> rtl/core/wsute_pkg.sv
// Package for the wall/standard/UTC time expander: beat widths, kind codes,
// date type and Gregorian day-stepping functions. No dependencies.
`default_nettype none

package wsute_pkg;

    localparam int IN_TDATA_W  = 64;   // 60 payload bits, padded to bytes
    localparam int IN_TUSER_W  = 2;
    localparam int OUT_TDATA_W = 112;  // 111 payload bits, padded to bytes
    localparam int YEAR_W      = 14;
    localparam int MONTH_W     = 4;
    localparam int DAY_W       = 5;
    localparam int MIN_IN_W    = 13;
    localparam int OFS_W       = 12;
    localparam int MIN_OUT_W   = 14;
    localparam int SUM_W       = 15;   // headroom for the raw minute sums

    localparam logic signed [SUM_W-1:0] ONE_DAY = 15'sd1440;

    // Result minutes always fall within this band: raw sums span
    // -8192..8191, and one normalization moves them by a day.
    localparam logic signed [MIN_OUT_W-1:0] MIN_OUT_LO = -14'sd6752;
    localparam logic signed [MIN_OUT_W-1:0] MIN_OUT_HI = 14'sd6751;

    typedef enum logic [1:0] {
        KIND_WALL = 2'd0,
        KIND_STD  = 2'd1,
        KIND_UTC  = 2'd2
    } t_kind;

    typedef struct packed {
        logic [DAY_W-1:0]   day;
        logic [MONTH_W-1:0] month;
        logic [YEAR_W-1:0]  year;
    } t_date;

    // Leap test without a divider: y%100 and y%400 reduce to y/4 being a
    // multiple of 25, checked through the inverse of 25 modulo 2^12.
    function automatic logic is_leap(input logic [YEAR_W-1:0] y);
        logic [11:0] q;
        logic [11:0] p;
        logic        div25;
        q     = y[13:2];
        p     = q * 12'd3113;
        div25 = (p <= 12'd163);
        return (y[1:0] == 2'd0) && (!div25 || (y[3:2] == 2'd0));
    endfunction

    // Out-of-range months count as 31 days long.
    function automatic logic [DAY_W-1:0] month_days(input logic [MONTH_W-1:0] m,
                                                    input logic leap);
        logic [DAY_W-1:0] n;
        case (m)
            4'd2:    n = leap ? 5'd29 : 5'd28;
            4'd4:    n = 5'd30;
            4'd6:    n = 5'd30;
            4'd9:    n = 5'd30;
            4'd11:   n = 5'd30;
            default: n = 5'd31;
        endcase
        return n;
    endfunction

    function automatic t_date step_fwd(input t_date d, input logic leap);
        t_date r;
        r = d;
        if (d.day < month_days(d.month, leap)) begin
            r.day = d.day + 5'd1;
        end else begin
            r.day = 5'd1;
            if (d.month >= 4'd12) begin
                r.month = 4'd1;
                r.year  = d.year + 14'd1;
            end else begin
                r.month = d.month + 4'd1;
            end
        end
        return r;
    endfunction

    // Stepping back across a year always lands on December 31, so only the
    // current year's leap flag is needed.
    function automatic t_date step_back(input t_date d, input logic leap);
        t_date r;
        r = d;
        if (d.day > 5'd1) begin
            r.day = d.day - 5'd1;
        end else if (d.month <= 4'd1) begin
            r.month = 4'd12;
            r.year  = d.year - 14'd1;
            r.day   = month_days(4'd12, leap);
        end else begin
            r.month = d.month - 4'd1;
            r.day   = month_days(d.month - 4'd1, leap);
        end
        return r;
    endfunction

endpackage

`default_nettype wire

>>> rtl/core/wall_standard_utc_time_expand_top.sv
// Top level of the wall/standard/UTC time expander: stream in, stream out.
// Depends on wsute_pkg for widths, kind codes and day-stepping functions.
`default_nettype none

// Path: an accepted input beat passes the input register and then the result
//   register before its result beat appears on the output.
// Throughput: 1 beat per cycle unless the output stalls; the input register
//   refills while a result waits, so ready drops only when both are full.
// Reset: synchronous, active low; clears both valid flags, payload is kept.
module wall_standard_utc_time_expand_top (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    // Input beat
    input  wire logic                              i_s_tvalid,
    output logic                                   o_s_tready,
    // tdata, low bit up: year[13:0], month[17:14], day[22:18],
    // minute_of_day[35:23], utc_offset[47:36], dst_delta[59:48], zero pad
    input  wire logic [wsute_pkg::IN_TDATA_W-1:0]  i_s_tdata,
    // tuser: time_kind[1:0]
    input  wire logic [wsute_pkg::IN_TUSER_W-1:0]  i_s_tuser,
    // Result beat
    output logic                                   o_m_tvalid,
    input  wire logic                              i_m_tready,
    // tdata, low bit up: wall_year[13:0], wall_month[17:14], wall_day[22:18],
    // wall_minutes[36:23], std_year[50:37], std_month[54:51],
    // std_day[59:55], std_minutes[73:60], utc_year[87:74],
    // utc_month[91:88], utc_day[96:92], utc_minutes[110:97], zero pad
    output logic [wsute_pkg::OUT_TDATA_W-1:0]      o_m_tdata
);
    import wsute_pkg::*;

    // Input register
    logic                   r_in_vld;
    logic [IN_TDATA_W-1:0]  r_in_data;
    logic [IN_TUSER_W-1:0]  r_in_kind;

    // Result register
    logic                   r_out_vld;
    logic [OUT_TDATA_W-1:0] r_out_data;
    logic [OUT_TDATA_W-1:0] n_out_data;

    logic s_acc;
    logic out_adv;
    logic move;

    // Output slot is free, or is emptied this cycle.
    assign out_adv    = !r_out_vld || i_m_tready;
    assign move       = r_in_vld && out_adv;
    assign o_s_tready = !r_in_vld || out_adv;
    assign s_acc      = i_s_tvalid && o_s_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (s_acc) begin
            r_in_vld <= 1'b1;
        end else if (move) begin
            r_in_vld <= 1'b0;
        end
    end

    // Capture the beat on accept, hold otherwise.
    always_ff @(posedge i_clk) begin
        if (s_acc) begin
            r_in_data <= i_s_tdata;
            r_in_kind <= i_s_tuser;
        end
    end

    // Field decode of the registered beat
    t_date                        in_date;
    logic signed [SUM_W-1:0]      t_min;
    logic signed [SUM_W-1:0]      t_ofs;
    logic signed [SUM_W-1:0]      t_dst;
    logic signed [SUM_W-1:0]      ofs_dst;
    logic                         leap;
    t_date                        date_fwd;
    t_date                        date_back;

    assign in_date.year  = r_in_data[13:0];
    assign in_date.month = r_in_data[17:14];
    assign in_date.day   = r_in_data[22:18];
    assign t_min   = {{(SUM_W-MIN_IN_W){r_in_data[35]}}, r_in_data[35:23]};
    assign t_ofs   = {{(SUM_W-OFS_W){r_in_data[47]}}, r_in_data[47:36]};
    assign t_dst   = {{(SUM_W-OFS_W){r_in_data[59]}}, r_in_data[59:48]};
    assign ofs_dst = t_ofs + t_dst;

    // All three tuples share the input date, so one forward and one backward
    // step serve every tuple; each only picks among them.
    assign leap      = is_leap(in_date.year);
    assign date_fwd  = step_fwd(in_date, leap);
    assign date_back = step_back(in_date, leap);

    // Index 0 wall, 1 standard, 2 UTC
    logic signed [SUM_W-1:0]     raw_min  [3];
    logic signed [SUM_W-1:0]     norm_min [3];
    t_date                       out_date [3];

    // Move the minutes into each time scale: std = utc + offset,
    // wall = std + delta. Unknown kind codes count as wall time.
    always_comb begin
        case (t_kind'(r_in_kind))
            KIND_STD: begin
                raw_min[0] = t_min + t_dst;
                raw_min[1] = t_min;
                raw_min[2] = t_min - t_ofs;
            end
            KIND_UTC: begin
                raw_min[0] = t_min + ofs_dst;
                raw_min[1] = t_min + t_ofs;
                raw_min[2] = t_min;
            end
            default: begin
                raw_min[0] = t_min;
                raw_min[1] = t_min - t_dst;
                raw_min[2] = t_min - ofs_dst;
            end
        endcase
    end

    // Normalize each tuple once: a full day or more either way steps the date.
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            if (raw_min[i] <= -ONE_DAY) begin
                out_date[i] = date_back;
                norm_min[i] = raw_min[i] + ONE_DAY;
            end else if (raw_min[i] >= ONE_DAY) begin
                out_date[i] = date_fwd;
                norm_min[i] = raw_min[i] - ONE_DAY;
            end else begin
                out_date[i] = in_date;
                norm_min[i] = raw_min[i];
            end
        end
    end

    assign n_out_data = {1'b0,
                         norm_min[2][MIN_OUT_W-1:0], out_date[2],
                         norm_min[1][MIN_OUT_W-1:0], out_date[1],
                         norm_min[0][MIN_OUT_W-1:0], out_date[0]};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (out_adv) begin
            r_out_vld <= r_in_vld;
        end
    end

    // Load a result only when the slot advances; hold while stalled.
    always_ff @(posedge i_clk) begin
        if (move) begin
            r_out_data <= n_out_data;
        end
    end

    assign o_m_tvalid = r_out_vld;
    assign o_m_tdata  = r_out_data;

endmodule

`default_nettype wire

>>> rtl/core/wsute_checker.sv
// Port-level checker for the time expander, bound to its top level.
// Depends on wsute_pkg and the assertion macro header.
`default_nettype none

`include "wall_standard_utc_time_expand_top_assert.svh"

module wsute_checker (
    input wire logic                              i_clk,
    input wire logic                              i_rst_n,
    input wire logic                              i_s_tvalid,
    input wire logic                              o_s_tready,
    input wire logic [wsute_pkg::IN_TDATA_W-1:0]  i_s_tdata,
    input wire logic [wsute_pkg::IN_TUSER_W-1:0]  i_s_tuser,
    input wire logic                              o_m_tvalid,
    input wire logic                              i_m_tready,
    input wire logic [wsute_pkg::OUT_TDATA_W-1:0] o_m_tdata
);
    import wsute_pkg::*;

    logic                        in_beat;
    logic signed [MIN_OUT_W-1:0] wall_min;
    logic signed [MIN_OUT_W-1:0] utc_min;

    assign in_beat  = i_s_tvalid && o_s_tready && (i_s_tuser == i_s_tuser)
                      && (i_s_tdata == i_s_tdata);
    assign wall_min = o_m_tdata[36:23];
    assign utc_min  = o_m_tdata[110:97];

    // Hold a stalled result beat.
    `WSUTE_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_m_tvalid && !i_m_tready, o_m_tvalid)
    `WSUTE_ASSERT_NEXT(a_out_stable, i_clk, i_rst_n, o_m_tvalid && !i_m_tready, $stable(o_m_tdata))
    // An output slot that drains this cycle always leaves room for a new beat.
    `WSUTE_ASSERT_NOW(a_ready_free, i_clk, i_rst_n, !o_m_tvalid || i_m_tready, o_s_tready)
    // One normalization keeps result minutes inside the fixed band.
    `WSUTE_ASSERT_NOW(a_min_band, i_clk, i_rst_n, o_m_tvalid, (wall_min >= MIN_OUT_LO) && (wall_min <= MIN_OUT_HI) && (utc_min >= MIN_OUT_LO) && (utc_min <= MIN_OUT_HI))
    // A beat accepted while the result slot is stalled had input ready high.
    `WSUTE_ASSERT_NOW(a_acc_room, i_clk, i_rst_n, in_beat && o_m_tvalid && !i_m_tready, o_s_tready)

endmodule

bind wall_standard_utc_time_expand_top wsute_checker u_wsute_checker (.*);

`default_nettype wire

>>> verif/testbench.sv
`timescale 1ns / 100ps
// Self-checking testbench for the wall/standard/UTC time expander stream block.
// Depends on wsute_pkg for widths and kind codes and on the top level RTL only.

module testbench;

    import wsute_pkg::*;

    // Kind code three has no package name; the block treats it as wall time.
    localparam logic [1:0] KIND_AS_WALL = 2'd3;

    localparam int IDLE_LIMIT    = 2000;  // cycles without any beat before giving up
    localparam int DRAIN_CYCLES  = 8;     // two-stage pipe, plus margin
    localparam int HOLD_CYCLES   = 400;   // long receiver hold-off for backpressure
    localparam int RANDOM_STAMPS = 1060;

    // One input beat; the last member sits in the lowest bits.
    typedef struct packed {
        logic [1:0]         kind;
        logic signed [11:0] dst;
        logic signed [11:0] offset;
        logic signed [12:0] minute;
        logic [4:0]         day;
        logic [3:0]         month;
        logic [13:0]        year;
    } stamp_t;

    // One normalized date-time tuple, laid out as on the result bus.
    typedef struct packed {
        logic signed [13:0] minutes;
        logic [4:0]         day;
        logic [3:0]         month;
        logic [13:0]        year;
    } civil_t;

    // The three views of one instant; wall time in the lowest bits.
    typedef struct packed {
        civil_t utc;
        civil_t standard;
        civil_t wall;
    } triple_t;

    logic                        i_clk;
    logic                        i_rst_n;
    logic                        i_s_tvalid;
    logic                        o_s_tready;
    logic [IN_TDATA_W-1:0]       i_s_tdata;
    logic [IN_TUSER_W-1:0]       i_s_tuser;
    logic                        o_m_tvalid;
    logic                        i_m_tready;
    logic [OUT_TDATA_W-1:0]      o_m_tdata;

    triple_t pending_triples[$];  // expected results, oldest first
    int      fault_count;
    int      beats_sent;
    int      raw_beats;
    int      results_checked;
    int      days_forward;
    int      days_back;
    int      idle_cycles;
    int      hold_request;
    int      stall_left;
    bit      pauses_on;
    bit      stalls_on;
    triple_t due_triple;
    triple_t seen_triple;

    wall_standard_utc_time_expand_top i_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),   // year, month, day, minute, offset, dst, pad
        .i_s_tuser  (i_s_tuser),   // time kind
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata)    // wall, standard, utc tuples, pad
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // ------------------------------------------------------------------
    // Calendar predictor
    // ------------------------------------------------------------------

    function automatic logic leap_year(logic [13:0] y);
        return ((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0);
    endfunction

    // Months outside 1..12 count as 31 days long.
    function automatic logic [4:0] month_length(logic [13:0] y, logic [3:0] m);
        case (m)
            4'd2:                      return leap_year(y) ? 5'd29 : 5'd28;
            4'd4, 4'd6, 4'd9, 4'd11:   return 5'd30;
            default:                   return 5'd31;
        endcase
    endfunction

    // Normalize one tuple: move the date by at most one day, keep 14 minute bits.
    function automatic civil_t settle_day(logic [13:0] y, logic [3:0] m,
                                          logic [4:0] d, int mins);
        civil_t t;
        if (mins <= -1440) begin
            days_back++;
            mins = mins + 1440;
            if (d > 5'd1) begin
                d = d - 5'd1;
            end else begin
                if (m <= 4'd1) begin
                    m = 4'd12;
                    y = y - 14'd1;   // wraps through year 0 to 16383
                end else begin
                    m = m - 4'd1;
                end
                d = month_length(y, m);
            end
        end else if (mins >= 1440) begin
            days_forward++;
            mins = mins - 1440;
            if (d < month_length(y, m)) begin
                d = d + 5'd1;
            end else begin
                d = 5'd1;
                if (m >= 4'd12) begin
                    m = 4'd1;
                    y = y + 14'd1;
                end else begin
                    m = m + 4'd1;
                end
            end
        end
        t.year    = y;
        t.month   = m;
        t.day     = d;
        t.minutes = 14'(mins);
        return t;
    endfunction

    // standard = utc + offset, wall = standard + dst; the tagged kind is the anchor.
    function automatic triple_t expand_instant(stamp_t s);
        triple_t r;
        int      t;
        int      off;
        int      dst;
        int      wall_min;
        int      std_min;
        int      utc_min;
        t   = s.minute;
        off = s.offset;
        dst = s.dst;
        if (s.kind == KIND_STD) begin
            std_min  = t;
            utc_min  = t - off;
            wall_min = t + dst;
        end else if (s.kind == KIND_UTC) begin
            utc_min  = t;
            std_min  = t + off;
            wall_min = t + off + dst;
        end else begin
            // wall time, and the unnamed fourth kind likewise
            wall_min = t;
            std_min  = t - dst;
            utc_min  = t - dst - off;
        end
        r.wall     = settle_day(s.year, s.month, s.day, wall_min);
        r.standard = settle_day(s.year, s.month, s.day, std_min);
        r.utc      = settle_day(s.year, s.month, s.day, utc_min);
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------

    function automatic stamp_t make_stamp(int y, int m, int d, int mins,
                                          logic [1:0] kind, int off, int dst);
        stamp_t s;
        s.year   = 14'(y);
        s.month  = 4'(m);
        s.day    = 5'(d);
        s.minute = 13'(mins);
        s.kind   = kind;
        s.offset = 12'(off);
        s.dst    = 12'(dst);
        return s;
    endfunction

    // Mostly short gaps, now and then a long one.
    function automatic int pick_pause();
        int r;
        r = $urandom_range(0, 99);
        if (r < 70) return 0;
        if (r < 95) return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    // A legal date with its minutes steered toward the day boundaries of
    // one of the three derived views.
    function automatic stamp_t calendar_stamp();
        stamp_t     s;
        int         pick;
        int         y;
        int         off;
        int         dst;
        int         base;
        int         shift;
        int         mins;
        logic [4:0] len;
        pick = $urandom_range(0, 9);
        if (pick == 0)      y = 1;
        else if (pick == 1) y = 9998;
        else if (pick == 2) y = 100 * $urandom_range(1, 99);
        else if (pick == 3) y = 4 * $urandom_range(1, 2499);
        else                y = $urandom_range(1, 9998);
        s.year  = 14'(y);
        s.month = 4'($urandom_range(1, 12));
        len     = month_length(s.year, s.month);
        pick    = $urandom_range(0, 3);
        if (pick == 0)      s.day = 5'd1;
        else if (pick == 1) s.day = len;
        else                s.day = 5'($urandom_range(1, len));
        s.kind = 2'($urandom_range(0, 3));

        if ($urandom_range(0, 1) == 0) off = 15 * $urandom_range(0, 104) - 720;
        else                           off = $urandom_range(0, 2880) - 1440;
        pick = $urandom_range(0, 3);
        if (pick == 0)      dst = 0;
        else if (pick == 1) dst = 60;
        else                dst = $urandom_range(0, 2880) - 1440;

        case ($urandom_range(0, 6))
            0:       base = -1440;
            1:       base = -1439;
            2:       base = 1439;
            3:       base = 1440;
            4:       base = 2880;
            5:       base = 0;
            default: base = $urandom_range(0, 4320) - 1440;
        endcase
        case ($urandom_range(0, 6))
            0:       shift = 0;
            1:       shift = off;
            2:       shift = -off;
            3:       shift = dst;
            4:       shift = -dst;
            5:       shift = off + dst;
            default: shift = -(off + dst);
        endcase
        mins = base + shift;
        if (mins < -1440 || mins > 2880) mins = base;
        s.minute = 13'(mins);
        s.offset = 12'(off);
        s.dst    = 12'(dst);
        return s;
    endfunction

    // Every field from raw random bits, out-of-range values included.
    function automatic stamp_t raw_stamp();
        logic [63:0] r;
        stamp_t      s;
        r = {$urandom, $urandom};
        s = r[$bits(stamp_t)-1:0];
        return s;
    endfunction

    // Offer one beat, hold it until taken, then log its expected result.
    task automatic offer_stamp(stamp_t s);
        int pause;
        @(negedge i_clk);
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= {{(IN_TDATA_W - 60){1'b0}}, s.dst, s.offset, s.minute,
                       s.day, s.month, s.year};
        i_s_tuser  <= s.kind;
        do @(posedge i_clk); while (!o_s_tready);
        pending_triples.push_back(expand_instant(s));
        beats_sent++;
        pause = pauses_on ? pick_pause() : 0;
        if (pause > 0) begin
            @(negedge i_clk);
            i_s_tvalid <= 1'b0;
            repeat (pause - 1) @(negedge i_clk);
        end
    endtask

    // ------------------------------------------------------------------
    // Receiver: random stalls plus the long hold-off on request
    // ------------------------------------------------------------------

    initial begin
        i_m_tready = 1'b0;
        stall_left = 0;
        forever begin
            @(negedge i_clk);
            if (hold_request > 0) begin
                stall_left   = hold_request;
                hold_request = 0;
            end
            if (stall_left > 0) begin
                i_m_tready <= 1'b0;
                stall_left--;
            end else begin
                i_m_tready <= 1'b1;
                // Start a stall on the next cycle, mostly short.
                if (stalls_on && $urandom_range(0, 99) < 15) begin
                    stall_left = ($urandom_range(0, 4) == 0) ? $urandom_range(8, 30)
                                                             : $urandom_range(1, 3);
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Result checking
    // ------------------------------------------------------------------

    task automatic check_field(string name, int want, int got);
        if (want != got) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            fault_count++;
        end
    endtask

    task automatic check_tuple(string tag, civil_t want, civil_t got);
        check_field({tag, "_year"},    want.year,    got.year);
        check_field({tag, "_month"},   want.month,   got.month);
        check_field({tag, "_day"},     want.day,     got.day);
        check_field({tag, "_minutes"}, want.minutes, got.minutes);
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            if (pending_triples.size() == 0) begin
                $error("result beat arrived with nothing pending");
                fault_count++;
            end else begin
                due_triple  = pending_triples.pop_front();
                seen_triple = o_m_tdata[$bits(triple_t)-1:0];
                check_tuple("wall", due_triple.wall,     seen_triple.wall);
                check_tuple("std",  due_triple.standard, seen_triple.standard);
                check_tuple("utc",  due_triple.utc,      seen_triple.utc);
                check_field("pad", 0, int'(o_m_tdata[OUT_TDATA_W-1:$bits(triple_t)]));
                results_checked++;
            end
        end
    end

    // Watchdog: abort when no beat moves on either side for too long.
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_s_tvalid && o_s_tready) || (o_m_tvalid && i_m_tready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= IDLE_LIMIT) begin
            $display("wall_standard_utc_time_expand_top regression: fail");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Minutes right at and next to one day either way, for every kind, and
    // the widest minute and offset values the fields can carry.
    task automatic test_normalization_edges();
        offer_stamp(make_stamp(2021, 6, 15, -1440, KIND_WALL, 0, 0));
        offer_stamp(make_stamp(2021, 6, 15, -1439, KIND_STD, 0, 0));
        offer_stamp(make_stamp(2021, 6, 15, 1439, KIND_UTC, 0, 0));
        offer_stamp(make_stamp(2021, 6, 15, 1440, KIND_AS_WALL, 0, 0));
        offer_stamp(make_stamp(2021, 6, 15, 1380, KIND_UTC, 60, 0));
        offer_stamp(make_stamp(2021, 6, 15, 0, KIND_WALL, 1440, 1440));
        offer_stamp(make_stamp(2021, 6, 15, -4096, KIND_WALL, 2047, 2047));
        offer_stamp(make_stamp(2021, 6, 15, 4095, KIND_UTC, 2047, 2047));
        offer_stamp(make_stamp(2021, 6, 15, -4096, KIND_UTC, -2048, -2048));
        offer_stamp(make_stamp(2021, 6, 15, 4095, KIND_AS_WALL, -2048, -2048));
    endtask

    // Month, year and leap-day crossings, the year wrap and out-of-range
    // months and days.
    task automatic test_calendar_edges();
        offer_stamp(make_stamp(9998, 12, 31, 1440, KIND_UTC, 0, 0));
        offer_stamp(make_stamp(1, 1, 1, -1440, KIND_UTC, 0, 0));
        offer_stamp(make_stamp(16383, 12, 31, 1500, KIND_STD, 0, 0));
        offer_stamp(make_stamp(0, 1, 1, -1500, KIND_STD, 0, 0));
        offer_stamp(make_stamp(0, 3, 1, -1440, KIND_WALL, 0, 0));
        offer_stamp(make_stamp(2024, 2, 28, 1440, KIND_UTC, 0, 0));
        offer_stamp(make_stamp(2023, 2, 28, 1440, KIND_UTC, 0, 0));
        offer_stamp(make_stamp(1900, 3, 1, -1440, KIND_UTC, 0, 0));
        offer_stamp(make_stamp(2000, 3, 1, -1440, KIND_UTC, 0, 0));
        offer_stamp(make_stamp(2023, 2, 29, 1440, KIND_UTC, 0, 0));
        offer_stamp(make_stamp(2022, 0, 31, 1440, KIND_UTC, 0, 0));
        offer_stamp(make_stamp(2022, 0, 1, -1440, KIND_UTC, 0, 0));
        offer_stamp(make_stamp(2022, 13, 31, 1440, KIND_UTC, 0, 0));
        offer_stamp(make_stamp(2022, 15, 1, -1440, KIND_UTC, 0, 0));
        offer_stamp(make_stamp(2022, 5, 0, -1440, KIND_UTC, 0, 0));
        offer_stamp(make_stamp(2022, 4, 31, 600, KIND_UTC, 0, 0));
    endtask

    // Hold the receiver off for a long stretch while beats keep coming, so
    // both pipeline registers fill and input ready drops.
    task automatic test_sink_hold();
        pauses_on    = 1'b0;
        hold_request = HOLD_CYCLES;
        repeat (40) offer_stamp(calendar_stamp());
    endtask

    // Mostly legal dates aimed at the day boundaries, the rest raw bits.
    // Input pauses and receiver stalls both switch off for every third stretch.
    task automatic test_random_mix(int count);
        for (int i = 0; i < count; i++) begin
            pauses_on = ((i / 150) % 3) != 2;
            stalls_on = ((i / 150) % 3) != 2;
            if ($urandom_range(0, 99) < 85) begin
                offer_stamp(calendar_stamp());
            end else begin
                offer_stamp(raw_stamp());
                raw_beats++;
            end
        end
    endtask

    initial begin
        i_rst_n         = 1'b0;
        i_s_tvalid      = 1'b0;
        i_s_tdata       = '0;
        i_s_tuser       = '0;
        fault_count     = 0;
        beats_sent      = 0;
        raw_beats       = 0;
        results_checked = 0;
        days_forward    = 0;
        days_back       = 0;
        idle_cycles     = 0;
        hold_request    = 0;
        pauses_on       = 1'b1;
        stalls_on       = 1'b1;
        repeat (10) @(negedge i_clk);
        i_rst_n = 1'b1;

        test_normalization_edges();
        test_calendar_edges();
        test_sink_hold();
        test_random_mix(RANDOM_STAMPS);

        // Drop valid, let the pipe drain, then wait out the drain margin.
        @(negedge i_clk);
        i_s_tvalid <= 1'b0;
        wait (pending_triples.size() == 0);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("covered %0d beats (%0d raw), %0d results compared",
                 beats_sent, raw_beats, results_checked);
        $display("day steps: %0d forward, %0d back, with a %0d-cycle receiver hold",
                 days_forward, days_back, HOLD_CYCLES);
        if (fault_count == 0) begin
            $display("wall_standard_utc_time_expand_top regression: pass");
        end else begin
            $display("wall_standard_utc_time_expand_top regression: fail");
        end
        $finish;
    end

endmodule

>>> filelist.f
+incdir+rtl/core
rtl/core/wsute_pkg.sv
rtl/core/wall_standard_utc_time_expand_top.sv
rtl/core/wsute_checker.sv
verif/testbench.sv
